@@ rtl/sff_pkg.sv @@
// Shared types and constants for the streaming FIR filter.
package sff_pkg;

  localparam int TAPS_W = 7;
  localparam int TAP_IDX_W = 6;
  localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd51;

  typedef enum logic {
    OP_FILTER     = 1'b0,
    OP_COEF_WRITE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                 vld;
    opcode_e              op;
    logic [TAP_IDX_W-1:0] idx;
  } sff_ctrl_t;

endpackage

@@ rtl/sff_tap_cell.sv @@
// One tap of the FIR chain: coefficient, optional history register and multiply-accumulate.
module sff_tap_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 39,
  parameter int CELL_IDX    = 0,
  parameter bit HAS_HIST    = 1'b1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [sff_pkg::TAPS_W-1:0]    taps_i,
  input  sff_pkg::sff_ctrl_t            ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] carry_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_i,
  input  logic signed [ACC_W-1:0]       acc_i,
  output sff_pkg::sff_ctrl_t            ctrl_o,
  output logic signed [SAMPLE_BITS-1:0] carry_o,
  output logic signed [SAMPLE_BITS-1:0] coef_o,
  output logic signed [ACC_W-1:0]       acc_o
);
  import sff_pkg::*;

  logic signed [SAMPLE_BITS-1:0]   coef_q;
  logic signed [SAMPLE_BITS-1:0]   val_q;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic signed [ACC_W-1:0]         acc_d;
  logic signed [ACC_W-1:0]         acc_q;
  sff_ctrl_t                       ctrl_q;
  logic                            tap_on;
  logic                            is_sample;
  logic                            coef_hit;

  assign tap_on    = CELL_IDX < int'(taps_i);
  assign is_sample = ctrl_i.vld && (ctrl_i.op == OP_FILTER);
  assign coef_hit  = ctrl_i.vld && (ctrl_i.op == OP_COEF_WRITE) && (int'(ctrl_i.idx) == CELL_IDX);
  assign prod      = carry_i * coef_q;
  assign acc_d     = tap_on ? acc_i + ACC_W'(prod) : acc_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_i;
      if (coef_hit) begin
        coef_q <= coef_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_q <= acc_d;
      val_q <= coef_i;
    end
  end

  generate
    if (HAS_HIST) begin : g_hist
      logic signed [SAMPLE_BITS-1:0] hist_q;
      logic signed [SAMPLE_BITS-1:0] carry_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          hist_q <= '0;
        end else if (adv_i && is_sample) begin
          hist_q <= carry_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          carry_q <= hist_q;
        end
      end

      assign carry_o = carry_q;
    end else begin : g_no_hist
      assign carry_o = '0;
    end
  endgenerate

  assign ctrl_o = ctrl_q;
  assign coef_o = val_q;
  assign acc_o  = acc_q;

endmodule

@@ rtl/streaming_fir_filter.sv @@
// Top level of the streaming FIR filter: a chain of tap cells and a rounding output stage.
// Unless stalled, one item per cycle enters and every item moves one tap cell per cycle.
// A sample's result passes one register stage per tap cell, the first loaded by the
// accepting edge, and then the output register.
// Reset clears all coefficients and the sample history and sets the tap count to 51.
// The chain stalls only while a result waits in the last cell behind a stalled output item.
module streaming_fir_filter #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sff_pkg::TAPS_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  input  logic [sff_pkg::TAP_IDX_W-1:0]     tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0]     tap_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o
);
  import sff_pkg::*;

  localparam int ACC_FULL = 2 * SAMPLE_BITS + $clog2(MAX_TAPS) + 1;
  localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (SAMPLE_BITS - 2);

  logic [TAPS_W-1:0]             taps_q;
  sff_ctrl_t                     ctrl  [0:MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] carry [0:MAX_TAPS-1];
  logic signed [SAMPLE_BITS-1:0] coefv [0:MAX_TAPS-1];
  logic signed [ACC_W-1:0]       acc   [0:MAX_TAPS];
  logic                          adv;
  logic                          hold;
  logic                          tail_res;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       shifted;
  logic                          fits;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          out_vld_d;
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_RESET;
    end else if (cfg_we_i) begin
      taps_q <= cfg_wdata_i;
    end
  end

  assign ctrl[0].vld = in_valid_i;
  assign ctrl[0].op  = opcode_e'(opcode_i);
  assign ctrl[0].idx = tap_index_i;
  assign carry[0]    = sample_in_i;
  assign coefv[0]    = tap_value_i;
  assign acc[0]      = '0;

  generate
    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      if (i < MAX_TAPS - 1) begin : g_mid
        sff_tap_cell #(
          .SAMPLE_BITS(SAMPLE_BITS),
          .ACC_W      (ACC_W),
          .CELL_IDX   (i),
          .HAS_HIST   (1'b1)
        ) u_cell (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .adv_i  (adv),
          .taps_i (taps_q),
          .ctrl_i (ctrl[i]),
          .carry_i(carry[i]),
          .coef_i (coefv[i]),
          .acc_i  (acc[i]),
          .ctrl_o (ctrl[i+1]),
          .carry_o(carry[i+1]),
          .coef_o (coefv[i+1]),
          .acc_o  (acc[i+1])
        );
      end else begin : g_last
        sff_tap_cell #(
          .SAMPLE_BITS(SAMPLE_BITS),
          .ACC_W      (ACC_W),
          .CELL_IDX   (i),
          .HAS_HIST   (1'b0)
        ) u_cell (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .adv_i  (adv),
          .taps_i (taps_q),
          .ctrl_i (ctrl[i]),
          .carry_i(carry[i]),
          .coef_i (coefv[i]),
          .acc_i  (acc[i]),
          .ctrl_o (ctrl[i+1]),
          .carry_o(),
          .coef_o (),
          .acc_o  (acc[i+1])
        );
      end
    end
  endgenerate

  assign tail_res   = ctrl[MAX_TAPS].vld && (ctrl[MAX_TAPS].op == OP_FILTER);
  assign hold       = tail_res && out_vld_q && out_stall_i;
  assign adv        = !hold;
  assign in_stall_o = hold;

  assign rnd     = acc[MAX_TAPS] + $signed(RND_BIAS);
  assign shifted = rnd >>> (SAMPLE_BITS - 1);
  assign fits    = (&shifted[ACC_W-1:SAMPLE_BITS-1]) || !(|shifted[ACC_W-1:SAMPLE_BITS-1]);
  assign sat     = fits ? shifted[SAMPLE_BITS-1:0]
                        : {shifted[ACC_W-1], {(SAMPLE_BITS-1){~shifted[ACC_W-1]}}};

  assign out_vld_d = (out_vld_q && out_stall_i) || tail_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail_res) begin
      sample_out_q <= sat;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = sample_out_q;

  a_coef_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl[MAX_TAPS].vld && (ctrl[MAX_TAPS].op == OP_COEF_WRITE) && !out_vld_q |=> !out_vld_q)
    else $error("A coefficient item produced a result.");

  a_blocked_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |=> tail_res && $stable(acc[MAX_TAPS]))
    else $error("A blocked result left the last cell.");

  a_zero_taps_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && tail_res && (taps_q == '0) |=> out_vld_q && (sample_out_q == '0))
    else $error("With no taps in use the output is not zero.");

endmodule

@@ test/tb_streaming_fir_filter.sv @@
// Self-checking testbench for the streaming FIR filter with a scoreboard that predicts each output.
`timescale 1ns / 1ps

class fir_scoreboard;
  localparam int NTAPS = 64;

  logic signed [15:0] coef [NTAPS];
  logic signed [15:0] hist [NTAPS-1];
  logic [sff_pkg::TAPS_W-1:0] taps;
  logic signed [15:0] filtered_q [$];
  int unsigned n_samples;
  int unsigned n_coef_writes;

  function new();
    foreach (coef[i]) coef[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    taps = sff_pkg::TAPS_RESET;
    n_samples = 0;
    n_coef_writes = 0;
  endfunction

  function void set_taps(logic [sff_pkg::TAPS_W-1:0] v);
    taps = v;
  endfunction

  function int pending();
    return filtered_q.size();
  endfunction

  function void note_input(sff_pkg::opcode_e op, logic signed [15:0] smp,
                           logic [sff_pkg::TAP_IDX_W-1:0] idx, logic signed [15:0] val);
    longint acc;
    int n;
    logic signed [15:0] d;
    if (op == sff_pkg::OP_COEF_WRITE) begin
      coef[idx] = val;
      n_coef_writes++;
      return;
    end
    n = (taps > NTAPS) ? NTAPS : int'(taps);
    acc = 0;
    for (int k = 0; k < n; k++) begin
      d = (k == 0) ? smp : hist[k-1];
      acc += longint'(coef[k]) * longint'(d);
    end
    for (int k = NTAPS - 2; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = smp;
    acc = (acc + (longint'(1) <<< 14)) >>> 15;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    filtered_q.insert(filtered_q.size(), acc[15:0]);
    n_samples++;
  endfunction

  function bit check_result(logic signed [15:0] got, output string msg);
    logic signed [15:0] want;
    if (filtered_q.size() == 0) begin
      msg = $sformatf("unexpected output item, sample_out %0d", got);
      return 1'b0;
    end
    want = filtered_q.pop_front();
    if (got !== want) begin
      msg = $sformatf("sample_out %0d, expected %0d", got, want);
      return 1'b0;
    end
    return 1'b1;
  endfunction
endclass

module tb_streaming_fir_filter;
  import sff_pkg::*;

  localparam int LATENCY = 65;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [TAPS_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic signed [15:0]   sample_in_i;
  logic [TAP_IDX_W-1:0] tap_index_i;
  logic signed [15:0]   tap_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [15:0]   sample_out_o;

  fir_scoreboard sb = new();
  int unsigned errors = 0;
  int unsigned n_settings = 0;
  int unsigned hold_cycles = 0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;

  streaming_fir_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .sample_in_i  (sample_in_i),
    .tap_index_i  (tap_index_i),
    .tap_value_i  (tap_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic report(string msg);
    errors++;
    if (errors <= 20) $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(negedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (!sb.check_result(sample_out_o, msg)) report(msg);
    end
  end

  initial begin : receiver
    int unsigned left;
    left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (!rx_idle_on) begin
        out_stall_i <= 1'b0;
        left = 0;
      end else if (left != 0) begin
        out_stall_i <= 1'b1;
        left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        left = $urandom_range(1, 9) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1: return 16'($signed($urandom_range(0, 2047)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_coef();
    if ($urandom_range(0, 1) == 0) return 16'($signed($urandom_range(0, 4095)) - 2048);
    return 16'($urandom);
  endfunction

  task automatic push_item(opcode_e op, logic signed [15:0] smp,
                           logic [TAP_IDX_W-1:0] idx, logic signed [15:0] val);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    sample_in_i <= smp;
    tap_index_i <= idx;
    tap_value_i <= val;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    sb.note_input(op, smp, idx, val);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 16) @(posedge clk_i);
  endtask

  task automatic write_taps(logic [TAPS_W-1:0] v);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_taps(v);
    n_settings++;
  endtask

  initial begin : stimulus
    logic [TAPS_W-1:0] taps_plan [8];
    taps_plan = '{7'd64, 7'd17, 7'd127, 7'd1, 7'd0, 7'd40, 7'd100, 7'd64};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    opcode_i    = 1'b0;
    sample_in_i = '0;
    tap_index_i = '0;
    tap_value_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(OP_FILTER, 16'sh7fff, '0, '0);
    push_item(OP_COEF_WRITE, '0, 6'd0, 16'sh7fff);
    push_item(OP_COEF_WRITE, '0, 6'd63, 16'sh8000);
    push_item(OP_COEF_WRITE, '0, 6'd1, 16'sh8000);
    push_item(OP_FILTER, 16'sh7fff, '1, '1);
    push_item(OP_FILTER, 16'sh8000, '0, '0);
    push_item(OP_FILTER, 16'shffff, '0, '0);
    push_item(OP_FILTER, 16'sh0001, '0, '0);
    push_item(OP_FILTER, 16'sh0000, '0, '0);
    write_taps(7'd0);
    push_item(OP_FILTER, 16'sh3039, '0, '0);
    write_taps(7'd127);
    push_item(OP_FILTER, 16'sh8000, '0, '0);
    push_item(OP_FILTER, 16'sh7fff, '0, '0);
    write_taps(7'd1);
    push_item(OP_FILTER, 16'sh8000, '0, '0);
    for (int i = 0; i < 4; i++) push_item(OP_COEF_WRITE, '0, 6'(i), 16'sh8000);
    write_taps(7'd4);
    repeat (4) push_item(OP_FILTER, 16'sh8000, '0, '0);
    repeat (4) push_item(OP_FILTER, 16'sh7fff, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      tx_idle_on = (ph != 3) && (ph != 7);
      rx_idle_on = (ph != 3) && (ph != 7);
      write_taps(taps_plan[ph]);
      for (int i = 0; i < 64; i++) push_item(OP_COEF_WRITE, 16'($urandom), 6'(i), rand_coef());
      if (ph == 2) hold_cycles = 400;
      for (int i = 0; i < 130; i++) begin
        if (ph == 5 && i == 65) drain_pipeline();
        if ($urandom_range(0, 9) == 0)
          push_item(OP_COEF_WRITE, 16'($urandom), 6'($urandom), rand_coef());
        else
          push_item(OP_FILTER, rand_sample(), 6'($urandom), 16'($urandom));
      end
    end
    drain_pipeline();

    $display("tb: %0d samples filtered and %0d coefficient writes over %0d tap-count settings,",
             sb.n_samples, sb.n_coef_writes, n_settings);
    $display("tb: with random gaps on both sides, a long output hold and full drains.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
